// ----- rtl/rhc_pkg.sv -----
// Shared types, constants and helpers for the RGB/HSV color conversion unit.
package rhc_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int GAIN_BITS    = 16;
  localparam int GAIN_FRAC    = 12;
  localparam int PADDR_BITS   = 3;
  localparam int PDATA_BITS   = 32;

  localparam logic [CHANNEL_BITS-1:0] FULL      = '1;
  localparam logic [CHANNEL_BITS-1:0] FULL_HALF = FULL >> 1;
  localparam logic [GAIN_BITS-1:0]    GAIN_ONE  = GAIN_BITS'(1 << GAIN_FRAC);
  localparam logic [GAIN_BITS-1:0]    GAIN_HALF = GAIN_BITS'(1 << (GAIN_FRAC - 1));
  localparam logic [2:0]              SEXT_MAX  = 3'd5;

  // register select, taken from paddr[2]
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  typedef enum logic [1:0] {
    MODE_RGB2HSV   = 2'd0,
    MODE_HSV2RGB   = 2'd1,
    MODE_SAT_SCALE = 2'd2,
    MODE_PASS      = 2'd3
  } mode_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] chan_a;
    logic [CHANNEL_BITS-1:0] chan_b;
    logic [CHANNEL_BITS-1:0] chan_c;
  } chan_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] out_a;
    logic [CHANNEL_BITS-1:0] out_b;
    logic [CHANNEL_BITS-1:0] out_c;
    logic                    hue_undefined;
  } chan_out_t;

  // x / FULL for x below 2^(2*CHANNEL_BITS), quotient known to fit a channel
  function automatic logic [CHANNEL_BITS-1:0] div_full(input logic [2*CHANNEL_BITS-1:0] x);
    logic [CHANNEL_BITS:0] rem;
    logic [CHANNEL_BITS:0] quo;
    rem = {1'b0, x[CHANNEL_BITS-1:0]} + {1'b0, x[2*CHANNEL_BITS-1:CHANNEL_BITS]};
    quo = {1'b0, x[2*CHANNEL_BITS-1:CHANNEL_BITS]};
    if (rem >= {FULL, 1'b0}) begin
      quo = quo + (CHANNEL_BITS+1)'(2);
    end else if (rem >= {1'b0, FULL}) begin
      quo = quo + (CHANNEL_BITS+1)'(1);
    end
    return quo[CHANNEL_BITS-1:0];
  endfunction

endpackage

// ----- rtl/rgb_hsv_convert_unit.sv -----
// RGB/HSV color conversion unit: top level with register port and full datapath.
// Accepts one pixel per clock while the last stage is empty or its result is
// taken; saturation and hue are formed by two 16-stage restoring dividers (one
// quotient bit per stage), followed by the sextant and the two multiply and
// divide-by-full-scale steps of the HSV to RGB back end. When the output is
// not taken the whole pipeline holds. mode and saturation_gain sit at byte
// addresses 0 and 4 and should be written while no pixel is in flight.
module rgb_hsv_convert_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rhc_pkg::chan_in_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rhc_pkg::chan_out_t                 out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rhc_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [rhc_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [rhc_pkg::PDATA_BITS-1:0]     prdata,
  output logic                               pready
);
  import rhc_pkg::*;

  localparam int N        = CHANNEL_BITS;
  localparam int W        = N + 3;
  localparam int DIV0     = 4;
  localparam int DIV_END  = DIV0 + N;
  localparam int ST_HSV   = DIV_END + 1;
  localparam int ST_GAIN  = DIV_END + 2;
  localparam int ST_SRC   = DIV_END + 3;
  localparam int ST_SIX   = DIV_END + 4;
  localparam int ST_SEXT  = DIV_END + 5;
  localparam int ST_MUL1  = DIV_END + 6;
  localparam int ST_DIV1  = DIV_END + 7;
  localparam int ST_MUL2  = DIV_END + 8;
  localparam int ST_DIV2  = DIV_END + 9;
  localparam int ST_OUT   = DIV_END + 10;

  typedef struct packed {
    chan_in_t pix;
    mode_e    mode;
    logic     flag;
  } ctx_t;

  typedef struct packed {
    logic [N-1:0] hue;
    logic [N-1:0] sat;
    logic [N-1:0] val;
  } hsv_t;

  // configuration
  mode_e                mode_q;
  logic [GAIN_BITS-1:0] gain_q;
  logic                 cfg_wr;

  // pipeline control
  logic              en;
  logic [ST_OUT:1]   vld_q;
  ctx_t              ctx_q [1:ST_OUT];

  // analysis front end
  logic [N-1:0] v1_d, x1_d, v1_q, x1_q;
  logic [N-1:0] v2_q, x2_q, ch2_q;
  logic [N-1:0] v3_q, ch3_q;
  logic [W-1:0] num3_d, num3_q;
  logic         flag3_d;
  logic [2*N-1:0] xs_d;
  logic [2*N+2:0] xh_d;

  // dividers: saturation (s) and hue (h)
  logic [N-1:0] rs_q [DIV0:DIV_END];
  logic [N-1:0] ls_q [DIV0:DIV_END];
  logic [N-1:0] ds_q [DIV0:DIV_END];
  logic [W-1:0] rh_q [DIV0:DIV_END];
  logic [N-1:0] lh_q [DIV0:DIV_END];
  logic [W-1:0] dh_q [DIV0:DIV_END];
  logic [N-1:0] rs_d [DIV0+1:DIV_END];
  logic [N-1:0] ls_d [DIV0+1:DIV_END];
  logic [W-1:0] rh_d [DIV0+1:DIV_END];
  logic [N-1:0] lh_d [DIV0+1:DIV_END];

  // HSV results and back end
  hsv_t hsv_d;
  hsv_t hsv_q [ST_HSV:ST_DIV2];
  logic [N+GAIN_BITS-1:0] prod_d, prod_q;
  logic [N+GAIN_BITS:0]   gsum;
  logic [N+4:0]           gscaled;
  logic [N-1:0] h_src_d, s_src_d, v_src_d, h_src_q, s_src_q, v_src_q;
  logic [W-1:0] six_d, six_q;
  logic [N-1:0] s_six_q, v_six_q;
  logic [2:0]   q0, ib, sext_d, sext_q;
  logic [N:0]   r0;
  logic [W-1:0] i_full, fw;
  logic [N-1:0] f_d, f_q, s_sext_q, v_sext_q;
  logic [2*N-1:0] pm_d, p1_d, p2_d, pm_q, p1_q, p2_q;
  logic [2:0]   sext_mul1_q, sext_div1_q, sext_mul2_q, sext_div2_q;
  logic [N-1:0] v_mul1_q, v_div1_q, v_mul2_q, v_div2_q;
  logic [N-1:0] m_div1_d, sf_d, s1f_d, m_div1_q, sf_q, s1f_q;
  logic [2*N-1:0] pn_d, pk_d, pn_q, pk_q;
  logic [N-1:0] m_mul2_q;
  logic [N-1:0] n_d, k_d, n_q, k_q, m_div2_q;
  logic [N-1:0] red, grn, blu;
  chan_out_t    out_d, out_q;

  // register port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAIN) ? PDATA_BITS'(gain_q) : PDATA_BITS'(mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RGB2HSV;
      gain_q <= GAIN_ONE;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GAIN) begin
        gain_q <= pwdata[GAIN_BITS-1:0];
      end else begin
        mode_q <= mode_e'(pwdata[1:0]);
      end
    end
  end

  // handshake
  assign en          = !vld_q[ST_OUT] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[ST_OUT];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ST_OUT-1:1], in_valid_i};
    end
  end

  // stage 1: max / min
  always_comb begin
    v1_d = in_data_i.chan_a;
    x1_d = in_data_i.chan_a;
    if (in_data_i.chan_b > v1_d) v1_d = in_data_i.chan_b;
    if (in_data_i.chan_c > v1_d) v1_d = in_data_i.chan_c;
    if (in_data_i.chan_b < x1_d) x1_d = in_data_i.chan_b;
    if (in_data_i.chan_c < x1_d) x1_d = in_data_i.chan_c;
  end

  // stage 3: hue numerator
  always_comb begin
    logic [W-1:0] rr, gg, bb, vv, xx, cc, c3, c5;
    rr = W'(ctx_q[2].pix.chan_a);
    gg = W'(ctx_q[2].pix.chan_b);
    bb = W'(ctx_q[2].pix.chan_c);
    vv = W'(v2_q);
    xx = W'(x2_q);
    cc = W'(ch2_q);
    c3 = (cc << 1) + cc;
    c5 = (cc << 2) + cc;
    if (rr == vv) begin
      num3_d = (gg == xx) ? c5 + (vv - bb) : cc - (vv - gg);
    end else if (gg == vv) begin
      num3_d = (bb == xx) ? cc + (vv - rr) : c3 - (vv - bb);
    end else begin
      num3_d = (rr == xx) ? c3 + (vv - gg) : c5 - (vv - rr);
    end
    flag3_d = (v2_q == '0) || (ch2_q == '0);
  end

  // stage 4: dividends
  assign xs_d = {ch3_q, {N{1'b0}}} - (2*N)'(ch3_q) + (2*N)'(v3_q >> 1);
  assign xh_d = {num3_q, {N{1'b0}}} - (2*N+3)'(num3_q)
              + (2*N+3)'({ch3_q, 1'b0}) + (2*N+3)'(ch3_q);

  // divider stages, one quotient bit each
  always_comb begin
    logic [N:0]   sh_s, df_s;
    logic [W:0]   sh_h, df_h;
    logic         ge_s, ge_h;
    for (int k = DIV0 + 1; k <= DIV_END; k++) begin
      sh_s = {rs_q[k-1], ls_q[k-1][N-1]};
      df_s = sh_s - {1'b0, ds_q[k-1]};
      ge_s = sh_s >= {1'b0, ds_q[k-1]};
      rs_d[k] = ge_s ? df_s[N-1:0] : sh_s[N-1:0];
      ls_d[k] = {ls_q[k-1][N-2:0], ge_s};
      sh_h = {rh_q[k-1], lh_q[k-1][N-1]};
      df_h = sh_h - {1'b0, dh_q[k-1]};
      ge_h = sh_h >= {1'b0, dh_q[k-1]};
      rh_d[k] = ge_h ? df_h[W-1:0] : sh_h[W-1:0];
      lh_d[k] = {lh_q[k-1][N-2:0], ge_h};
    end
  end

  // HSV result, gain, HSV source
  always_comb begin
    hsv_d.hue = ctx_q[DIV_END].flag ? '0 : lh_q[DIV_END];
    hsv_d.sat = ctx_q[DIV_END].flag ? '0 : ls_q[DIV_END];
    hsv_d.val = ds_q[DIV_END];
    prod_d = (N+GAIN_BITS)'(hsv_q[ST_HSV].sat) * (N+GAIN_BITS)'(gain_q);
    gsum    = (N+GAIN_BITS+1)'(prod_q) + (N+GAIN_BITS+1)'(GAIN_HALF);
    gscaled = gsum[N+GAIN_BITS:GAIN_FRAC];
    if (ctx_q[ST_GAIN].mode == MODE_HSV2RGB) begin
      h_src_d = ctx_q[ST_GAIN].pix.chan_a;
      s_src_d = ctx_q[ST_GAIN].pix.chan_b;
      v_src_d = ctx_q[ST_GAIN].pix.chan_c;
    end else begin
      h_src_d = hsv_q[ST_GAIN].hue;
      s_src_d = (gscaled > (N+5)'(FULL)) ? FULL : gscaled[N-1:0];
      v_src_d = hsv_q[ST_GAIN].val;
    end
  end

  // sextant and fraction
  always_comb begin
    six_d  = W'({h_src_q, 2'b00}) + W'({h_src_q, 1'b0});
    q0     = six_q[W-1:N];
    r0     = (N+1)'(six_q[N-1:0]) + (N+1)'(q0);
    ib     = q0 + 3'(r0 >= (N+1)'(FULL));
    sext_d = (ib > SEXT_MAX) ? SEXT_MAX : ib;
    i_full = {sext_d, {N{1'b0}}} - W'(sext_d);
    fw     = six_q - i_full;
    f_d    = (fw > W'(FULL)) ? FULL : fw[N-1:0];
  end

  // fractional products
  always_comb begin
    pm_d     = (2*N)'(v_sext_q) * (2*N)'(FULL - s_sext_q);
    p1_d     = (2*N)'(s_sext_q) * (2*N)'(f_q);
    p2_d     = (2*N)'(s_sext_q) * (2*N)'(FULL - f_q);
    m_div1_d = div_full(pm_q + (2*N)'(FULL_HALF));
    sf_d     = div_full(p1_q + (2*N)'(FULL_HALF));
    s1f_d    = div_full(p2_q + (2*N)'(FULL_HALF));
    pn_d     = (2*N)'(v_div1_q) * (2*N)'(FULL - sf_q);
    pk_d     = (2*N)'(v_div1_q) * (2*N)'(FULL - s1f_q);
    n_d      = div_full(pn_q + (2*N)'(FULL_HALF));
    k_d      = div_full(pk_q + (2*N)'(FULL_HALF));
  end

  // RGB by sextant and final select
  always_comb begin
    case (sext_div2_q)
      3'd0: begin red = v_div2_q; grn = k_q;      blu = m_div2_q; end
      3'd1: begin red = n_q;      grn = v_div2_q; blu = m_div2_q; end
      3'd2: begin red = m_div2_q; grn = v_div2_q; blu = k_q;      end
      3'd3: begin red = m_div2_q; grn = n_q;      blu = v_div2_q; end
      3'd4: begin red = k_q;      grn = m_div2_q; blu = v_div2_q; end
      default: begin red = v_div2_q; grn = m_div2_q; blu = n_q; end
    endcase
    case (ctx_q[ST_DIV2].mode)
      MODE_RGB2HSV: begin
        out_d.out_a         = hsv_q[ST_DIV2].hue;
        out_d.out_b         = hsv_q[ST_DIV2].sat;
        out_d.out_c         = hsv_q[ST_DIV2].val;
        out_d.hue_undefined = ctx_q[ST_DIV2].flag;
      end
      MODE_HSV2RGB: begin
        out_d.out_a         = red;
        out_d.out_b         = grn;
        out_d.out_c         = blu;
        out_d.hue_undefined = 1'b0;
      end
      MODE_SAT_SCALE: begin
        if (gain_q == GAIN_ONE) begin
          out_d.out_a = ctx_q[ST_DIV2].pix.chan_a;
          out_d.out_b = ctx_q[ST_DIV2].pix.chan_b;
          out_d.out_c = ctx_q[ST_DIV2].pix.chan_c;
        end else begin
          out_d.out_a = red;
          out_d.out_b = grn;
          out_d.out_c = blu;
        end
        out_d.hue_undefined = ctx_q[ST_DIV2].flag;
      end
      default: begin
        out_d.out_a         = ctx_q[ST_DIV2].pix.chan_a;
        out_d.out_b         = ctx_q[ST_DIV2].pix.chan_b;
        out_d.out_c         = ctx_q[ST_DIV2].pix.chan_c;
        out_d.hue_undefined = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[1] <= '{pix: in_data_i, mode: mode_q, flag: 1'b0};
      ctx_q[2] <= ctx_q[1];
      ctx_q[3] <= '{pix: ctx_q[2].pix, mode: ctx_q[2].mode, flag: flag3_d};
      for (int k = 4; k <= ST_OUT; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end

      v1_q   <= v1_d;
      x1_q   <= x1_d;
      v2_q   <= v1_q;
      x2_q   <= x1_q;
      ch2_q  <= v1_q - x1_q;
      v3_q   <= v2_q;
      ch3_q  <= ch2_q;
      num3_q <= num3_d;

      rs_q[DIV0] <= xs_d[2*N-1:N];
      ls_q[DIV0] <= xs_d[N-1:0];
      ds_q[DIV0] <= v3_q;
      rh_q[DIV0] <= xh_d[2*N+2:N];
      lh_q[DIV0] <= xh_d[N-1:0];
      dh_q[DIV0] <= W'({ch3_q, 2'b00}) + W'({ch3_q, 1'b0});
      for (int k = DIV0 + 1; k <= DIV_END; k++) begin
        rs_q[k] <= rs_d[k];
        ls_q[k] <= ls_d[k];
        ds_q[k] <= ds_q[k-1];
        rh_q[k] <= rh_d[k];
        lh_q[k] <= lh_d[k];
        dh_q[k] <= dh_q[k-1];
      end

      hsv_q[ST_HSV] <= hsv_d;
      for (int k = ST_HSV + 1; k <= ST_DIV2; k++) begin
        hsv_q[k] <= hsv_q[k-1];
      end

      prod_q  <= prod_d;
      h_src_q <= h_src_d;
      s_src_q <= s_src_d;
      v_src_q <= v_src_d;

      six_q   <= six_d;
      s_six_q <= s_src_q;
      v_six_q <= v_src_q;

      sext_q   <= sext_d;
      f_q      <= f_d;
      s_sext_q <= s_six_q;
      v_sext_q <= v_six_q;

      pm_q        <= pm_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      sext_mul1_q <= sext_q;
      v_mul1_q    <= v_sext_q;

      m_div1_q    <= m_div1_d;
      sf_q        <= sf_d;
      s1f_q       <= s1f_d;
      sext_div1_q <= sext_mul1_q;
      v_div1_q    <= v_mul1_q;

      pn_q        <= pn_d;
      pk_q        <= pk_d;
      m_mul2_q    <= m_div1_q;
      sext_mul2_q <= sext_div1_q;
      v_mul2_q    <= v_div1_q;

      n_q         <= n_d;
      k_q         <= k_d;
      m_div2_q    <= m_mul2_q;
      sext_div2_q <= sext_mul2_q;
      v_div2_q    <= v_mul2_q;

      out_q <= out_d;
    end
  end

  a_hsv2rgb_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ctx_q[ST_OUT].mode == MODE_HSV2RGB |-> !out_data_o.hue_undefined)
    else $error("hue_undefined set on hsv to rgb result");

  a_undef_hue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ctx_q[ST_OUT].mode == MODE_RGB2HSV && out_data_o.hue_undefined
    |-> out_data_o.out_a == '0 && out_data_o.out_b == '0)
    else $error("undefined hue with nonzero hue or saturation");

  a_stall_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[1])
    else $error("accepted pixel not in first stage");

endmodule

// ----- tb/rgb_hsv_convert_unit_checker.sv -----
// Checker for the color conversion unit: predicts each pixel result and compares transfers.
module rgb_hsv_convert_unit_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  rhc_pkg::chan_in_t     in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  rhc_pkg::chan_out_t    out_data_i,
  input  rhc_pkg::mode_e        mode_i,
  input  logic [15:0]           gain_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rhc_pkg::*;

  localparam longint unsigned FS = 65535;

  chan_out_t pixel_q[$];
  int mismatches;

  function automatic longint unsigned frac_mul(longint unsigned a, longint unsigned b);
    return (a * b + FS / 2) / FS;
  endfunction

  // returns 1 when hue is undefined; h, s, v outputs
  function automatic bit to_hsv(input longint unsigned r, g, b,
                                output longint unsigned h, s, v);
    longint unsigned lo, c, num;
    v = r; lo = r;
    if (g > v) v = g;
    if (b > v) v = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    h = 0; s = 0;
    c = v - lo;
    if (v == 0 || c == 0) return 1'b1;
    s = (c * FS + v / 2) / v;
    if (r == v) num = (g == lo) ? 5 * c + (v - b) : c - (v - g);
    else if (g == v) num = (b == lo) ? c + (v - r) : 3 * c - (v - b);
    else num = (r == lo) ? 3 * c + (v - g) : 5 * c - (v - r);
    h = (num * FS + 3 * c) / (6 * c);
    if (h > FS) h = FS;
    return 1'b0;
  endfunction

  function automatic void to_rgb(input longint unsigned h, s, v,
                                 output longint unsigned r, g, b);
    longint unsigned sx, f, m, n, k;
    sx = (6 * h) / FS;
    if (sx > 5) sx = 5;
    f = 6 * h - sx * FS;
    if (f > FS) f = FS;
    m = frac_mul(v, FS - s);
    n = frac_mul(v, FS - frac_mul(s, f));
    k = frac_mul(v, FS - frac_mul(s, FS - f));
    case (sx)
      0: begin r = v; g = k; b = m; end
      1: begin r = n; g = v; b = m; end
      2: begin r = m; g = v; b = k; end
      3: begin r = m; g = n; b = v; end
      4: begin r = k; g = m; b = v; end
      default: begin r = v; g = m; b = n; end
    endcase
  endfunction

  function automatic chan_out_t convert_pixel(chan_in_t px, mode_e md, logic [15:0] gn);
    chan_out_t res;
    longint unsigned a, b, c, h, s, v, o0, o1, o2;
    bit undef;
    a = px.chan_a; b = px.chan_b; c = px.chan_c;
    o0 = a; o1 = b; o2 = c; undef = 1'b0;
    case (md)
      MODE_RGB2HSV: begin
        undef = to_hsv(a, b, c, o0, o1, o2);
      end
      MODE_HSV2RGB: begin
        to_rgb(a, b, c, o0, o1, o2);
      end
      MODE_SAT_SCALE: begin
        undef = to_hsv(a, b, c, h, s, v);
        if (gn != GAIN_ONE) begin
          s = (s * gn + GAIN_HALF) >> GAIN_FRAC;
          if (s > FS) s = FS;
          to_rgb(h, s, v, o0, o1, o2);
        end
      end
      default: ;
    endcase
    res.out_a = o0[15:0];
    res.out_b = o1[15:0];
    res.out_c = o2[15:0];
    res.hue_undefined = undef;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    chan_out_t exp_px;
    if (!rst_ni) begin
      pixel_q.delete();
      mismatches <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected pixel transfer: %h", out_data_i);
        end else begin
          exp_px = pixel_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_px !== out_data_i) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp a=%h b=%h c=%h u=%b got a=%h b=%h c=%h u=%b",
                       exp_px.out_a, exp_px.out_b, exp_px.out_c, exp_px.hue_undefined,
                       out_data_i.out_a, out_data_i.out_b, out_data_i.out_c,
                       out_data_i.hue_undefined);
          end
        end
      end
      if (in_valid_i && in_ready_i) pixel_q.push_back(convert_pixel(in_data_i, mode_i, gain_i));
    end
  end

  assign pending_o = pixel_q.size();
  assign fail_count_o = mismatches + ((pending_o != 0) ? 0 : 0);
endmodule

// ----- tb/rgb_hsv_convert_unit_tb.sv -----
// Testbench top: drives pixels and register writes and reports the verdict.
module rgb_hsv_convert_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rhc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  chan_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  chan_out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic pready;

  mode_e cur_mode = MODE_RGB2HSV;
  logic [15:0] cur_gain = GAIN_ONE;
  int fail_count, pending, checked;
  bit feeding = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rgb_hsv_convert_unit u_dut (.*);

  rgb_hsv_convert_unit_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .mode_i(cur_mode), .gain_i(cur_gain),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  task automatic reg_write(logic sel, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {sel, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (sel == REG_MODE) cur_mode <= mode_e'(val[1:0]);
    else cur_gain <= val[15:0];
  endtask

  // valid stays high after a transfer until the next gap or drain
  task automatic send_pixel(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{chan_a: a, chan_b: b, chan_c: c};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));
      3: return 16'($urandom_range(65532, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    int w;
    if (out_ready_i && out_valid_o) begin
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      if (w != 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end else if (!out_ready_i) begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    logic [15:0] s, g, v;
    mode_e modes[4];
    logic [15:0] gains[5];
    modes = '{MODE_RGB2HSV, MODE_HSV2RGB, MODE_SAT_SCALE, MODE_PASS};
    gains = '{16'h0000, 16'hFFFF, GAIN_ONE, 16'h0800, 16'h1800};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, gray, primaries, hue of full turn
    reg_write(REG_MODE, MODE_RGB2HSV);
    reg_write(REG_GAIN, 32'h0000_FFFF);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'h0000, 16'h0001);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(16'h8000, 16'h8000, 16'h7FFF);
    drain();
    reg_write(REG_MODE, MODE_HSV2RGB);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h2AAA, 16'h8000, 16'hFFFF);
    send_pixel(16'hD555, 16'h0000, 16'h1234);
    drain();
    reg_write(REG_MODE, MODE_SAT_SCALE);
    send_pixel(16'hFFFF, 16'h0000, 16'h8000);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC);
    drain();
    reg_write(REG_GAIN, 32'h0000_0000);
    send_pixel(16'hFFFF, 16'h0000, 16'h8000);
    drain();
    reg_write(REG_GAIN, GAIN_ONE);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    drain();
    reg_write(REG_MODE, MODE_PASS);
    send_pixel(16'hFFFF, 16'h0000, 16'h5555);
    drain();
    // random phases over modes and gains
    for (int ph = 0; ph < 24; ph++) begin
      reg_write(REG_MODE, modes[ph % 4]);
      reg_write(REG_GAIN, (ph % 3 == 0) ? gains[(ph / 4) % 5] : 16'($urandom));
      for (int n = 0; n < 60; n++) begin
        s = rand_chan(); g = rand_chan(); v = rand_chan();
        if ($urandom_range(0, 3) == 0) g = s;
        if ($urandom_range(0, 3) == 0) v = s;
        send_pixel(s, g, v);
      end
      drain();
    end
    $display("covered all four modes, gains from zero to full scale, %0d pixels checked",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("rgb_hsv_convert_unit_tb passed");
    end else begin
      $display("rgb_hsv_convert_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("rgb_hsv_convert_unit_tb failed");
    $finish;
  end
endmodule
